[rtl/sas_pkg.sv]
`timescale 1ns / 1ps
package sas_pkg;

    localparam int unsigned STICK_W   = 12;
    localparam int unsigned HOLD_W    = 8;
    localparam int unsigned IDLE_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [STICK_W-1:0] LOCK_THR_RST = 12'd1200;
    localparam logic [STICK_W-1:0] LOCK_YAW_RST = 12'd1800;
    localparam logic [STICK_W-1:0] LOW_THR_RST  = 12'd1150;
    localparam logic [STICK_W-1:0] HIGH_THR_RST = 12'd1800;
    localparam logic [STICK_W-1:0] IDLE_THR_RST = 12'd1020;
    localparam logic [HOLD_W-1:0]  HOLD_RST     = 8'd5;
    localparam logic [IDLE_W-1:0]  IDLE_RST     = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCK_THR  = 3'd0,
        CFG_LOCK_YAW  = 3'd1,
        CFG_LOW_THR   = 3'd2,
        CFG_HIGH_THR  = 3'd3,
        CFG_IDLE_THR  = 3'd4,
        CFG_HOLD_TKS  = 3'd5,
        CFG_IDLE_TKS  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_WAIT_LOW  = 3'd0,
        PH_WAIT_HIGH = 3'd1,
        PH_WAIT_LOW2 = 3'd2,
        PH_ARMING    = 3'd3,
        PH_ARMED     = 3'd4,
        PH_LOCKING   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [STICK_W-1:0] lock_throttle_below;
        logic [STICK_W-1:0] lock_yaw_above;
        logic [STICK_W-1:0] low_throttle_below;
        logic [STICK_W-1:0] high_throttle_above;
        logic [STICK_W-1:0] idle_throttle_below;
        logic [HOLD_W-1:0]  high_hold_ticks;
        logic [IDLE_W-1:0]  idle_disarm_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic [HOLD_W-1:0]  hold_cnt;
        logic [IDLE_W-1:0]  idle_cnt;
        logic               armed;
        logic               led_solid;
    } t_state;

    typedef struct packed {
        logic baro_zero;
        logic flash_load;
    } t_pulse;

endpackage

[rtl/sas_in_if.sv]
`timescale 1ns / 1ps
interface sas_in_if;
    logic                         valid;
    logic                         ready;
    logic [sas_pkg::STICK_W-1:0]  throttle;
    logic [sas_pkg::STICK_W-1:0]  yaw_stick;
    logic                         armed_cleared;

    modport source (output valid, output throttle, output yaw_stick,
                    output armed_cleared, input ready);
    modport sink   (input valid, input throttle, input yaw_stick,
                    input armed_cleared, output ready);
endinterface

[rtl/sas_out_if.sv]
`timescale 1ns / 1ps
interface sas_out_if;
    logic       valid;
    logic       ready;
    logic       armed;
    logic       led_solid;
    logic       baro_zero;
    logic       flash_load;
    logic [2:0] phase;

    modport source (output valid, output armed, output led_solid, output baro_zero,
                    output flash_load, output phase, input ready);
    modport sink   (input valid, input armed, input led_solid, input baro_zero,
                    input flash_load, input phase, output ready);
endinterface

[rtl/sas_cfg_regs.sv]
`timescale 1ns / 1ps
module sas_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sas_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output sas_pkg::t_cfg                   o_cfg
);

    sas_pkg::t_cfg r_cfg;
    sas_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (sas_pkg::t_cfg_idx'(i_cfg_idx))
                sas_pkg::CFG_LOCK_THR: begin
                    n_cfg.lock_throttle_below = i_cfg_data[sas_pkg::STICK_W-1:0];
                end
                sas_pkg::CFG_LOCK_YAW: begin
                    n_cfg.lock_yaw_above = i_cfg_data[sas_pkg::STICK_W-1:0];
                end
                sas_pkg::CFG_LOW_THR: begin
                    n_cfg.low_throttle_below = i_cfg_data[sas_pkg::STICK_W-1:0];
                end
                sas_pkg::CFG_HIGH_THR: begin
                    n_cfg.high_throttle_above = i_cfg_data[sas_pkg::STICK_W-1:0];
                end
                sas_pkg::CFG_IDLE_THR: begin
                    n_cfg.idle_throttle_below = i_cfg_data[sas_pkg::STICK_W-1:0];
                end
                sas_pkg::CFG_HOLD_TKS: begin
                    n_cfg.high_hold_ticks = i_cfg_data[sas_pkg::HOLD_W-1:0];
                end
                sas_pkg::CFG_IDLE_TKS: begin
                    n_cfg.idle_disarm_ticks = i_cfg_data[sas_pkg::IDLE_W-1:0];
                end
                default: begin
                    // ignore writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lock_throttle_below <= sas_pkg::LOCK_THR_RST;
            r_cfg.lock_yaw_above      <= sas_pkg::LOCK_YAW_RST;
            r_cfg.low_throttle_below  <= sas_pkg::LOW_THR_RST;
            r_cfg.high_throttle_above <= sas_pkg::HIGH_THR_RST;
            r_cfg.idle_throttle_below <= sas_pkg::IDLE_THR_RST;
            r_cfg.high_hold_ticks     <= sas_pkg::HOLD_RST;
            r_cfg.idle_disarm_ticks   <= sas_pkg::IDLE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/sas_step.sv]
`timescale 1ns / 1ps
module sas_step (
    input  sas_pkg::t_cfg                   i_cfg,
    input  sas_pkg::t_state                 i_state,
    input  logic [sas_pkg::STICK_W-1:0]     i_throttle,
    input  logic [sas_pkg::STICK_W-1:0]     i_yaw_stick,
    input  logic                            i_armed_cleared,
    output sas_pkg::t_state                 o_state,
    output sas_pkg::t_pulse                 o_pulse
);

    logic                           gesture;
    logic                           thr_low;
    logic                           thr_high;
    logic                           thr_idle;
    logic                           armed_in;
    sas_pkg::t_phase                phase_in;
    logic [sas_pkg::HOLD_W-1:0]     hold_inc;
    logic [sas_pkg::IDLE_W-1:0]     idle_inc;

    assign gesture  = (i_throttle < i_cfg.lock_throttle_below)
                   && (i_yaw_stick > i_cfg.lock_yaw_above);
    assign thr_low  = i_throttle < i_cfg.low_throttle_below;
    assign thr_high = i_throttle > i_cfg.high_throttle_above;
    assign thr_idle = i_throttle < i_cfg.idle_throttle_below;
    // external clear lands before the phase logic
    assign armed_in = i_armed_cleared ? 1'b0 : i_state.armed;
    // disarm gesture overrides the current phase in the same tick
    assign phase_in = gesture ? sas_pkg::PH_LOCKING : i_state.phase;
    assign hold_inc = i_state.hold_cnt + sas_pkg::HOLD_W'(1);
    assign idle_inc = i_state.idle_cnt + sas_pkg::IDLE_W'(1);

    always_comb begin
        o_state       = i_state;
        o_state.armed = armed_in;
        o_state.phase = phase_in;
        case (phase_in)
            sas_pkg::PH_WAIT_LOW: begin
                if (thr_low) begin
                    o_state.phase = sas_pkg::PH_WAIT_HIGH;
                end
            end
            sas_pkg::PH_WAIT_HIGH: begin
                if (thr_high) begin
                    if (hold_inc > i_cfg.high_hold_ticks) begin
                        o_state.hold_cnt = '0;
                        o_state.phase    = sas_pkg::PH_WAIT_LOW2;
                    end else begin
                        o_state.hold_cnt = hold_inc;
                    end
                end
            end
            sas_pkg::PH_WAIT_LOW2: begin
                if (thr_low) begin
                    o_state.phase = sas_pkg::PH_ARMING;
                end
            end
            sas_pkg::PH_ARMING: begin
                o_state.armed     = 1'b1;
                o_state.led_solid = 1'b1;
                o_state.phase     = sas_pkg::PH_ARMED;
            end
            sas_pkg::PH_ARMED: begin
                if (thr_idle) begin
                    o_state.idle_cnt = idle_inc;
                    if (i_state.idle_cnt > i_cfg.idle_disarm_ticks) begin
                        o_state.phase = sas_pkg::PH_LOCKING;
                    end
                end else if (!armed_in) begin
                    o_state.phase = sas_pkg::PH_LOCKING;
                end else begin
                    o_state.idle_cnt = '0;
                end
            end
            sas_pkg::PH_LOCKING: begin
                o_state.led_solid = 1'b0;
                o_state.idle_cnt  = '0;
                o_state.armed     = 1'b0;
                o_state.phase     = sas_pkg::PH_WAIT_LOW;
            end
            default: begin
                o_state.phase = sas_pkg::PH_LOCKING;
            end
        endcase
    end

    always_comb begin
        o_pulse = '0;
        case (phase_in)
            sas_pkg::PH_WAIT_LOW2: begin
                o_pulse.baro_zero = thr_low;
            end
            sas_pkg::PH_LOCKING: begin
                o_pulse.flash_load = 1'b1;
            end
            default: begin
                // no pulse in the other phases
            end
        endcase
    end

endmodule

[rtl/stick_arming_sequencer.sv]
`timescale 1ns / 1ps
// Stick arming sequencer: one stick sample item per control tick in, one status item out.
// Input channel i_in carries throttle, yaw_stick and armed_cleared; output channel
// o_out carries armed, led_solid, the baro_zero and flash_load pulses and the phase.
// Both channels move an item on a clock edge where valid and ready are high.
// Thresholds and tick counts sit in seven registers written through the plain
// write port (i_cfg_we, i_cfg_idx, i_cfg_data); write them only while no item is
// in flight. Indexes beyond the list are ignored.
// The item's transition is computed from the port values and the sequencer state,
// and the result lands in the output register on the accept edge. Throughput is one
// item per cycle while the receiver does not stall; the single output register sets it.
// When the receiver stalls, the output register holds its item and i_in.ready
// drops until it is taken; a new item is accepted in the same cycle the held one
// leaves. Reset (synchronous, active low) clears the output valid, returns the
// sequence to the wait-low phase with zero counters, disarmed and LED flashing,
// and loads the register defaults.
module stick_arming_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sas_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    sas_in_if.sink                          i_in,
    sas_out_if.source                       o_out
);

    sas_pkg::t_cfg      cfg;
    sas_pkg::t_state    r_state;
    sas_pkg::t_state    n_state;
    sas_pkg::t_pulse    step_pulse;
    sas_pkg::t_pulse    r_pulse;
    logic               r_out_valid;
    logic               in_take;

    sas_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sas_step u_step (
        .i_cfg           (cfg),
        .i_state         (r_state),
        .i_throttle      (i_in.throttle),
        .i_yaw_stick     (i_in.yaw_stick),
        .i_armed_cleared (i_in.armed_cleared),
        .o_state         (n_state),
        .o_pulse         (step_pulse)
    );

    // accept whenever the output slot is empty or being drained this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    // sequencer state; the output item mirrors it, so the state register doubles
    // as the result register for armed, LED mode and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= sas_pkg::PH_WAIT_LOW;
            r_state.hold_cnt  <= '0;
            r_state.idle_cnt  <= '0;
            r_state.armed     <= 1'b0;
            r_state.led_solid <= 1'b0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // pulses live only in the result item; hold them while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pulse <= step_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.armed      = r_state.armed;
    assign o_out.led_solid  = r_state.led_solid;
    assign o_out.baro_zero  = r_pulse.baro_zero;
    assign o_out.flash_load = r_pulse.flash_load;
    assign o_out.phase      = r_state.phase;

    // locking always ends disarmed and back at the first phase
    a_flash_ends_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pulse.flash_load)
            |-> (r_state.phase == sas_pkg::PH_WAIT_LOW) && !r_state.armed
                && !r_state.led_solid)
        else $error("flash_load without completed lock");

    // barometer zeroing only on entry to the arming phase
    a_baro_on_arming: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pulse.baro_zero) |-> (r_state.phase == sas_pkg::PH_ARMING))
        else $error("baro_zero outside arming entry");

    // the armed phase is only reached with the LED solid
    a_armed_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == sas_pkg::PH_ARMED) |-> r_state.led_solid)
        else $error("armed phase with flashing LED");

    // state advances only on an accepted item
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_take |=> $stable(r_state))
        else $error("sequencer state moved without an item");

endmodule

[verif/tb_stick_arming_sequencer.sv]
`timescale 1ns / 1ps
module tb_stick_arming_sequencer;
    import sas_pkg::*;

    // Index past the end of the register list; the block must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;
    localparam logic [STICK_W-1:0]   STICK_MAX    = 12'hFFF;

    // One stick sample as presented on the input channel.
    typedef struct packed {
        logic [STICK_W-1:0] throttle;
        logic [STICK_W-1:0] yaw_stick;
        logic               armed_cleared;
    } stick_item_t;

    // One status item as it should leave the output channel.
    typedef struct packed {
        logic       armed;
        logic       led_solid;
        logic       baro_zero;
        logic       flash_load;
        logic [2:0] phase;
    } status_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    sas_in_if  in_if ();
    sas_out_if out_if ();

    stick_arming_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Sticks waiting to be sent, and status items the block owes us.
    stick_item_t stick_q[$];
    status_t     expected_status_q[$];
    int          items_queued;
    int          n_fail;

    // Idle pattern state for the sender and the receiver.
    int send_gap, send_run, take_hold, take_run;
    bit send_quiet, take_quiet;

    // Shadow of the register file and of the sequencer state.
    t_cfg               m_cfg;
    t_phase             m_phase;
    logic [HOLD_W-1:0]  m_hold;
    logic [IDLE_W-1:0]  m_idle;
    logic               m_armed;
    logic               m_led_solid;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Hard stop in case the block hangs or drops an item.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Draw a random wait for the idle pattern; every so often switch to a stretch that never waits.
    function automatic int draw_wait(inout int run_left, inout bit quiet);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            quiet    = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    // Advance the shadow sequencer by one tick and return the status it reports.
    function automatic status_t advance_sequencer(logic [STICK_W-1:0] thr,
                                                  logic [STICK_W-1:0] yaw,
                                                  logic cleared);
        status_t           s;
        logic [IDLE_W-1:0] idle_prev;
        s = '0;
        // An outside clear lands before anything else this tick.
        if (cleared)
            m_armed = 1'b0;
        // Disarm gesture overrides the phase and is handled in the same tick.
        if (thr < m_cfg.lock_throttle_below && yaw > m_cfg.lock_yaw_above)
            m_phase = PH_LOCKING;
        case (m_phase)
            PH_WAIT_LOW: begin
                if (thr < m_cfg.low_throttle_below)
                    m_phase = PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH: begin
                // Hold count survives throttle drops and locking; wraps at 8 bits.
                if (thr > m_cfg.high_throttle_above) begin
                    m_hold = m_hold + 1'b1;
                    if (m_hold > m_cfg.high_hold_ticks) begin
                        m_hold  = '0;
                        m_phase = PH_WAIT_LOW2;
                    end
                end
            end
            PH_WAIT_LOW2: begin
                if (thr < m_cfg.low_throttle_below) begin
                    m_phase     = PH_ARMING;
                    s.baro_zero = 1'b1;
                end
            end
            PH_ARMING: begin
                m_armed     = 1'b1;
                m_led_solid = 1'b1;
                m_phase     = PH_ARMED;
            end
            PH_ARMED: begin
                // Idle throttle wins over a cleared flag; compare the count before bumping it.
                if (thr < m_cfg.idle_throttle_below) begin
                    idle_prev = m_idle;
                    m_idle    = m_idle + 1'b1;
                    if (idle_prev > m_cfg.idle_disarm_ticks)
                        m_phase = PH_LOCKING;
                end else if (!m_armed) begin
                    m_phase = PH_LOCKING;
                end else begin
                    m_idle = '0;
                end
            end
            PH_LOCKING: begin
                m_led_solid  = 1'b0;
                m_idle       = '0;
                s.flash_load = 1'b1;
                m_armed      = 1'b0;
                m_phase      = PH_WAIT_LOW;
            end
            default: begin
                m_phase = PH_LOCKING;
            end
        endcase
        s.armed     = m_armed;
        s.led_solid = m_led_solid;
        s.phase     = m_phase;
        return s;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Sender: present queued sticks, honor gaps, and predict on every accepted item.
    always @(posedge i_clk) begin : drive_stick
        stick_item_t nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                expected_status_q.push_back(advance_sequencer(in_if.throttle, in_if.yaw_stick,
                                                              in_if.armed_cleared));
            // Hold the current item until it is taken; then gap or advance.
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    in_if.valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end else if (stick_q.size() > 0) begin
                    nxt = stick_q.pop_front();
                    in_if.valid         <= 1'b1;
                    in_if.throttle      <= nxt.throttle;
                    in_if.yaw_stick     <= nxt.yaw_stick;
                    in_if.armed_cleared <= nxt.armed_cleared;
                    send_gap            <= draw_wait(send_run, send_quiet);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random, compare every taken status item with the oldest prediction.
    always @(posedge i_clk) begin : take_status
        status_t want;
        int      n;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            take_hold    <= 0;
        end else if (out_if.valid && out_if.ready) begin
            if (expected_status_q.size() == 0) begin
                n_fail++;
                $display("%0t: status item with nothing expected, expected none, got phase %0d",
                         $time, out_if.phase);
            end else begin
                want = expected_status_q.pop_front();
                check_field("armed", want.armed, out_if.armed);
                check_field("led_solid", want.led_solid, out_if.led_solid);
                check_field("baro_zero", want.baro_zero, out_if.baro_zero);
                check_field("flash_load", want.flash_load, out_if.flash_load);
                check_field("phase", want.phase, out_if.phase);
            end
            n = draw_wait(take_run, take_quiet);
            if (n == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                take_hold    <= n - 1;
            end
        end else if (!out_if.ready) begin
            if (take_hold == 0)
                out_if.ready <= 1'b1;
            else
                take_hold <= take_hold - 1;
        end
    end

    task automatic push_stick(logic [STICK_W-1:0] thr, logic [STICK_W-1:0] yaw, logic cleared);
        stick_item_t it;
        it.throttle      = thr;
        it.yaw_stick     = yaw;
        it.armed_cleared = cleared;
        stick_q.push_back(it);
        items_queued++;
    endtask

    // Throttle strictly below / above a bound; fall back to anything when none exists.
    function automatic logic [STICK_W-1:0] thr_below(logic [STICK_W-1:0] bound);
        return (bound == 0) ? STICK_W'($urandom) : STICK_W'($urandom_range(0, int'(bound) - 1));
    endfunction

    function automatic logic [STICK_W-1:0] thr_above(logic [STICK_W-1:0] bound);
        return (bound == STICK_MAX) ? STICK_W'($urandom)
                                    : STICK_W'($urandom_range(int'(bound) + 1, 4095));
    endfunction

    // Yaw that can never complete the disarm gesture.
    function automatic logic [STICK_W-1:0] calm_yaw();
        return STICK_W'($urandom_range(0, int'(m_cfg.lock_yaw_above)));
    endfunction

    function automatic logic rare_clear();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic queue_gesture();
        if (m_cfg.lock_throttle_below == 0 || m_cfg.lock_yaw_above == STICK_MAX)
            push_stick(STICK_W'($urandom), STICK_W'($urandom), rare_clear());
        else
            push_stick(thr_below(m_cfg.lock_throttle_below),
                       STICK_W'($urandom_range(int'(m_cfg.lock_yaw_above) + 1, 4095)),
                       rare_clear());
    endtask

    // Full arming sequence with random content, then a stretch in the armed phase.
    task automatic queue_arming_run();
        int highs;
        int pick;
        push_stick(thr_below(m_cfg.low_throttle_below), calm_yaw(), rare_clear());
        highs = int'(m_cfg.high_hold_ticks) + 1;
        if (highs > 40)
            highs = $urandom_range(1, 40);
        repeat (highs) begin
            // Drop the throttle now and then; the hold count must keep its value.
            if ($urandom_range(0, 5) == 0)
                push_stick(STICK_W'($urandom_range(0, int'(m_cfg.high_throttle_above))),
                           calm_yaw(), rare_clear());
            push_stick(thr_above(m_cfg.high_throttle_above), calm_yaw(), rare_clear());
        end
        push_stick(thr_below(m_cfg.low_throttle_below), calm_yaw(), rare_clear());
        push_stick(STICK_W'($urandom), calm_yaw(), 1'b0);
        repeat ($urandom_range(1, 12)) begin
            pick = $urandom_range(0, 9);
            if (pick == 0 && m_cfg.idle_disarm_ticks <= 30) begin
                // Idle long enough to trip the automatic disarm.
                repeat (int'(m_cfg.idle_disarm_ticks) + 2)
                    push_stick(thr_below(m_cfg.idle_throttle_below), calm_yaw(), rare_clear());
            end else if (pick == 1) begin
                push_stick(STICK_W'($urandom), calm_yaw(), 1'b1);
            end else if (pick == 2) begin
                push_stick(thr_below(m_cfg.idle_throttle_below), calm_yaw(), 1'b0);
            end else begin
                push_stick(STICK_W'($urandom_range(int'(m_cfg.idle_throttle_below), 4095)),
                           calm_yaw(), 1'b0);
            end
        end
        if ($urandom_range(0, 3) == 0)
            queue_gesture();
    endtask

    // Mostly well-formed arming runs, some gestures and some raw noise.
    task automatic queue_random_phase(int n);
        int start;
        int pick;
        start = items_queued;
        while (items_queued - start < n) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                repeat ($urandom_range(1, 4))
                    push_stick(STICK_W'($urandom), STICK_W'($urandom), 1'($urandom));
            end else if (pick == 9) begin
                queue_gesture();
            end else begin
                queue_arming_run();
            end
        end
    endtask

    // Wait until every stick is sent and every status item has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        while (stick_q.size() != 0 || in_if.valid || expected_status_q.size() != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LOCK_THR: m_cfg.lock_throttle_below = val[STICK_W-1:0];
            CFG_LOCK_YAW: m_cfg.lock_yaw_above      = val[STICK_W-1:0];
            CFG_LOW_THR:  m_cfg.low_throttle_below  = val[STICK_W-1:0];
            CFG_HIGH_THR: m_cfg.high_throttle_above = val[STICK_W-1:0];
            CFG_IDLE_THR: m_cfg.idle_throttle_below = val[STICK_W-1:0];
            CFG_HOLD_TKS: m_cfg.high_hold_ticks     = val[HOLD_W-1:0];
            CFG_IDLE_TKS: m_cfg.idle_disarm_ticks   = val[IDLE_W-1:0];
            default: ;
        endcase
    endtask

    // Write all seven registers; junk in the unused upper bits must be dropped.
    task automatic set_registers(logic [STICK_W-1:0] lock_thr, logic [STICK_W-1:0] lock_yaw,
                                 logic [STICK_W-1:0] low_thr, logic [STICK_W-1:0] high_thr,
                                 logic [STICK_W-1:0] idle_thr, logic [HOLD_W-1:0] hold_tks,
                                 logic [IDLE_W-1:0] idle_tks);
        write_reg(CFG_LOCK_THR, {4'($urandom), lock_thr});
        write_reg(CFG_LOCK_YAW, {4'($urandom), lock_yaw});
        write_reg(CFG_LOW_THR,  {4'($urandom), low_thr});
        write_reg(CFG_HIGH_THR, {4'($urandom), high_thr});
        write_reg(CFG_IDLE_THR, {4'($urandom), idle_thr});
        write_reg(CFG_HOLD_TKS, {8'($urandom), hold_tks});
        write_reg(CFG_IDLE_TKS, idle_tks);
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.throttle      = '0;
        in_if.yaw_stick     = '0;
        in_if.armed_cleared = 1'b0;
        out_if.ready        = 1'b0;
        n_fail              = 0;
        items_queued        = 0;
        send_run            = 0;
        take_run            = 0;
        send_quiet          = 1'b0;
        take_quiet          = 1'b0;

        m_cfg.lock_throttle_below = LOCK_THR_RST;
        m_cfg.lock_yaw_above      = LOCK_YAW_RST;
        m_cfg.low_throttle_below  = LOW_THR_RST;
        m_cfg.high_throttle_above = HIGH_THR_RST;
        m_cfg.idle_throttle_below = IDLE_THR_RST;
        m_cfg.high_hold_ticks     = HOLD_RST;
        m_cfg.idle_disarm_ticks   = IDLE_RST;
        m_phase     = PH_WAIT_LOW;
        m_hold      = '0;
        m_idle      = '0;
        m_armed     = 1'b0;
        m_led_solid = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through the sequence on the reset thresholds.
        push_stick(12'd4095, 12'd0,    1'b0);  // max throttle while waiting low: stay
        push_stick(12'd0,    12'd0,    1'b1);  // min throttle with a clear: advance
        push_stick(12'd4095, 12'd2000, 1'b0);  // high, no gesture at full throttle
        push_stick(12'd1900, 12'd1500, 1'b0);
        push_stick(12'd1900, 12'd1500, 1'b0);
        push_stick(12'd1500, 12'd1500, 1'b0);  // throttle dips: hold count kept
        push_stick(12'd1900, 12'd1500, 1'b0);
        push_stick(12'd1900, 12'd1500, 1'b0);
        push_stick(12'd1801, 12'd1500, 1'b0);  // sixth high tick passes the hold bound
        push_stick(12'd1000, 12'd1500, 1'b0);  // low again: barometer pulse
        push_stick(12'd1500, 12'd1500, 1'b0);  // arming tick: armed, LED solid
        push_stick(12'd1019, 12'd1500, 1'b1);  // idle throttle with a clear: idle wins
        push_stick(12'd1500, 12'd1500, 1'b0);  // leave idle: the clear now locks
        push_stick(12'd1500, 12'd1500, 1'b0);  // locking tick: flash load
        push_stick(12'd1199, 12'd1801, 1'b0);  // disarm gesture at its bounds
        push_stick(12'd1200, 12'd4095, 1'b0);  // throttle on the bound: no gesture
        push_stick(12'd1100, 12'd1500, 1'b0);
        push_stick(12'd4095, 12'd4095, 1'b1);
        push_stick(12'd0,    12'd4095, 1'b0);  // gesture out of the wait-high phase
        queue_random_phase(120);
        wait_drained();

        // Low extremes: no gesture, any throttle below the maximum is low, any nonzero throttle is high.
        set_registers(12'd0, 12'd0, STICK_MAX, 12'd0, 12'd0, 8'd0, 16'd0);
        close_writes();
        queue_random_phase(60);
        wait_drained();

        // High extremes: the sequence cannot leave the first phase.
        set_registers(STICK_MAX, STICK_MAX, 12'd0, STICK_MAX, STICK_MAX, 8'hFF, 16'hFFFF);
        close_writes();
        queue_random_phase(40);
        wait_drained();

        // Hold bound at its maximum: park in wait-high and wrap the hold count.
        set_registers(12'd1200, 12'd1800, 12'd1150, 12'd1800, 12'd1020, 8'hFF, 16'hFFFF);
        close_writes();
        queue_gesture();
        push_stick(thr_below(m_cfg.low_throttle_below), calm_yaw(), 1'b0);
        repeat (300)
            push_stick(thr_above(m_cfg.high_throttle_above), calm_yaw(), rare_clear());
        wait_drained();

        // Short hold and fast idle disarm; the write past the list must not land.
        set_registers(12'd1200, 12'd1800, 12'd1150, 12'd1800, 12'd1500, 8'd3, 16'd2);
        write_reg(CFG_IDX_NONE, 16'($urandom));
        close_writes();
        queue_random_phase(120);
        wait_drained();

        repeat (3) begin
            set_registers(STICK_W'($urandom), STICK_W'($urandom), STICK_W'($urandom),
                          STICK_W'($urandom), STICK_W'($urandom),
                          HOLD_W'($urandom_range(0, 10)), IDLE_W'($urandom_range(0, 30)));
            close_writes();
            queue_random_phase(80);
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
